// ----- src/rvm_pkg.sv -----
`default_nettype none
package rvm_pkg;

    // fixed machine shape
    localparam int REGS      = 16;
    localparam int TEMP_BASE = 16;
    localparam int Q_DEPTH   = 2;

    // defaults for the sizing parameters of the top level
    localparam int DEF_TEMPS_PER_FRAME = 16;
    localparam int DEF_FRAMES          = 16;
    localparam int DEF_PARAM_DEPTH     = 64;
    localparam int DEF_DATA_WORDS      = 256;

    // stream payload widths
    localparam int S_TDATA_W = 104;
    localparam int S_TUSER_W = 5;
    localparam int M_TDATA_W = 88;

    // commands
    localparam logic [4:0] CMD_NOP     = 5'd0;
    localparam logic [4:0] CMD_STO     = 5'd1;
    localparam logic [4:0] CMD_STI     = 5'd2;
    localparam logic [4:0] CMD_STP     = 5'd3;
    localparam logic [4:0] CMD_STM     = 5'd4;
    localparam logic [4:0] CMD_STD     = 5'd5;
    localparam logic [4:0] CMD_ADD     = 5'd6;
    localparam logic [4:0] CMD_SUB     = 5'd7;
    localparam logic [4:0] CMD_INC     = 5'd8;
    localparam logic [4:0] CMD_DEC     = 5'd9;
    localparam logic [4:0] CMD_MUL     = 5'd10;
    localparam logic [4:0] CMD_DIV     = 5'd11;
    localparam logic [4:0] CMD_EQU     = 5'd12;
    localparam logic [4:0] CMD_NEQ     = 5'd13;
    localparam logic [4:0] CMD_LTH     = 5'd14;
    localparam logic [4:0] CMD_LEQ     = 5'd15;
    localparam logic [4:0] CMD_GTH     = 5'd16;
    localparam logic [4:0] CMD_GEQ     = 5'd17;
    localparam logic [4:0] CMD_PSH     = 5'd18;
    localparam logic [4:0] CMD_POP     = 5'd19;
    localparam logic [4:0] CMD_JMP     = 5'd20;
    localparam logic [4:0] CMD_JPZ     = 5'd21;
    localparam logic [4:0] CMD_JNZ     = 5'd22;
    localparam logic [4:0] CMD_CLL     = 5'd23;
    localparam logic [4:0] CMD_ALT     = 5'd24;
    localparam logic [4:0] CMD_CLX     = 5'd25;
    localparam logic [4:0] CMD_RET     = 5'd26;
    localparam logic [4:0] CMD_START   = 5'd27;
    localparam logic [4:0] CMD_ARG     = 5'd28;
    localparam logic [4:0] CMD_PRELOAD = 5'd29;

    // status codes
    localparam logic [3:0] ST_RUN   = 4'd0;
    localparam logic [3:0] ST_OK    = 4'd1;
    localparam logic [3:0] ST_OUTP  = 4'd2;
    localparam logic [3:0] ST_TEMP  = 4'd3;
    localparam logic [3:0] ST_DATA  = 4'd4;
    localparam logic [3:0] ST_EMPTY = 4'd5;
    localparam logic [3:0] ST_INV   = 4'd6;
    localparam logic [3:0] ST_NIMP  = 4'd7;
    localparam logic [3:0] ST_DIV0  = 4'd8;
    localparam logic [3:0] ST_OVF   = 4'd9;

    // item classes
    localparam logic [1:0] KIND_INSN    = 2'd0;
    localparam logic [1:0] KIND_START   = 2'd1;
    localparam logic [1:0] KIND_ARG     = 2'd2;
    localparam logic [1:0] KIND_PRELOAD = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  cmd;
        logic [7:0]  op1;
        logic [7:0]  op2;
        logic [63:0] imm;
        logic [15:0] target;
        logic [7:0]  addr;
        logic        op1_tmp;
        logic        op2_tmp;
        logic [7:0]  t1;
        logic [7:0]  t2;
    } rvm_item_t;

    function automatic int clog2_min1(input int n);
        return (n <= 1) ? 1 : $clog2(n);
    endfunction

endpackage
`default_nettype wire

// ----- src/register_vm_execute_unit.sv -----
`default_nettype none
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  instruction beat (tdata, tuser = cmd)
// m_axis    out  m_axis_tvalid / m_axis_tready  status, next pc, accumulator
// apb       in   psel, penable, pwrite, pready  program_length @0x0, data_words_used @0x4
//
// a plain instruction passes through the back end in turn: pop, op1 read, op2 read, execute
// multiply adds the MUL and FIN states (16-bit digit per cycle), divide adds DIV and FIN (one quotient bit a cycle)
// register file and temporaries live in single-read-port rams, so operands are read in turn
// reset is synchronous, active low; state comes up running at pc 0, all registers zero
// a front register and a 2-deep queue keep taking beats while the back end or m_axis stalls
module register_vm_execute_unit #(
    parameter int TEMPS_PER_FRAME = rvm_pkg::DEF_TEMPS_PER_FRAME,
    parameter int FRAMES          = rvm_pkg::DEF_FRAMES,
    parameter int PARAM_DEPTH     = rvm_pkg::DEF_PARAM_DEPTH,
    parameter int DATA_WORDS      = rvm_pkg::DEF_DATA_WORDS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // op1[7:0], op2[15:8], imm[79:16], target[95:80], data_addr[103:96]
    input  wire logic [rvm_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // cmd[4:0]
    input  wire logic [rvm_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // status[3:0], next_pc[19:4], acc[83:20], zero pad
    output logic [rvm_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import rvm_pkg::*;

    logic [15:0] plen_reg;
    logic [8:0]  dwu_reg;
    logic        cfg_wr;

    logic        fq_valid;
    logic        fq_ready;
    rvm_item_t   fq_item;
    logic        qb_valid;
    logic        qb_ready;
    rvm_item_t   qb_item;

    // config registers, decoded on paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = paddr[2] ? {23'd0, dwu_reg} : {16'd0, plen_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg <= '0;
            dwu_reg  <= '0;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                dwu_reg <= pwdata[8:0];
            end else begin
                plen_reg <= pwdata[15:0];
            end
        end
    end

    // front: take beat, classify
    rvm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .out_valid     (fq_valid),
        .out_ready     (fq_ready),
        .out_item      (fq_item)
    );

    // decoupling queue
    rvm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    // back: execute and hold the result beat
    rvm_back #(
        .TEMPS_PER_FRAME (TEMPS_PER_FRAME),
        .FRAMES          (FRAMES),
        .PARAM_DEPTH     (PARAM_DEPTH),
        .DATA_WORDS      (DATA_WORDS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (qb_valid),
        .q_ready         (qb_ready),
        .q_item          (qb_item),
        .program_length  (plen_reg),
        .data_words_used (dwu_reg),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata)
    );
endmodule
`default_nettype wire

// ----- src/rvm_ram.sv -----
`default_nettype none
module rvm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW   = rvm_pkg::clog2_min1(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- src/rvm_front.sv -----
`default_nettype none
module rvm_front (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [rvm_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic [rvm_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output rvm_pkg::rvm_item_t                   out_item
);
    import rvm_pkg::*;

    logic      valid_reg;
    rvm_item_t item_reg;
    rvm_item_t item_next;

    // classify the incoming beat
    always_comb begin
        item_next.cmd    = s_axis_tuser;
        item_next.op1    = s_axis_tdata[7:0];
        item_next.op2    = s_axis_tdata[15:8];
        item_next.imm    = s_axis_tdata[79:16];
        item_next.target = s_axis_tdata[95:80];
        item_next.addr   = s_axis_tdata[103:96];
        item_next.op1_tmp = item_next.op1 >= 8'(TEMP_BASE);
        item_next.op2_tmp = item_next.op2 >= 8'(TEMP_BASE);
        item_next.t1 = item_next.op1 - 8'(TEMP_BASE);
        item_next.t2 = item_next.op2 - 8'(TEMP_BASE);
        unique case (s_axis_tuser)
            CMD_START:   item_next.kind = KIND_START;
            CMD_ARG:     item_next.kind = KIND_ARG;
            CMD_PRELOAD: item_next.kind = KIND_PRELOAD;
            default:     item_next.kind = KIND_INSN;
        endcase
    end

    assign s_axis_tready = !valid_reg || out_ready;
    assign out_valid     = valid_reg;
    assign out_item      = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            item_reg <= item_next;
        end
    end
endmodule
`default_nettype wire

// ----- src/rvm_queue.sv -----
`default_nettype none
module rvm_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire rvm_pkg::rvm_item_t in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output rvm_pkg::rvm_item_t      out_item
);
    import rvm_pkg::*;

    localparam int PW = clog2_min1(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    rvm_item_t       entry_reg [Q_DEPTH];
    logic [PW-1:0]   wptr_reg;
    logic [PW-1:0]   rptr_reg;
    logic [CW-1:0]   cnt_reg;
    logic            push;
    logic            pop;

    assign in_ready  = cnt_reg != CW'(Q_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_item  = entry_reg[rptr_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
        if (push) begin
            entry_reg[wptr_reg] <= in_item;
        end
    end
endmodule
`default_nettype wire

// ----- src/rvm_div.sv -----
`default_nettype none
module rvm_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [63:0] divisor,
    output logic             done,
    output logic [63:0]      quotient
);
    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg;
    logic [63:0] quo_reg;
    logic [63:0] rem_reg;
    logic [63:0] mb_reg;
    logic [64:0] shifted;
    logic [64:0] diff;

    // restoring divide on magnitudes, one quotient bit a cycle
    assign shifted = {rem_reg, quo_reg[63]};
    assign diff    = shifted - {1'b0, mb_reg};

    assign done     = done_reg;
    assign quotient = neg_reg ? (64'd0 - quo_reg) : quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 6'd63) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        if (start) begin
            cnt_reg <= '0;
            neg_reg <= dividend[63] ^ divisor[63];
            quo_reg <= dividend[63] ? (64'd0 - dividend) : dividend;
            mb_reg  <= divisor[63] ? (64'd0 - divisor) : divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (!diff[64]) begin
                rem_reg <= diff[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end else begin
                rem_reg <= shifted[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// ----- src/rvm_back.sv -----
`default_nettype none
module rvm_back #(
    parameter int TEMPS_PER_FRAME = rvm_pkg::DEF_TEMPS_PER_FRAME,
    parameter int FRAMES          = rvm_pkg::DEF_FRAMES,
    parameter int PARAM_DEPTH     = rvm_pkg::DEF_PARAM_DEPTH,
    parameter int DATA_WORDS      = rvm_pkg::DEF_DATA_WORDS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    output logic                               q_ready,
    input  wire rvm_pkg::rvm_item_t            q_item,
    input  wire logic [15:0]                   program_length,
    input  wire logic [8:0]                    data_words_used,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [rvm_pkg::M_TDATA_W-1:0]      m_axis_tdata
);
    import rvm_pkg::*;

    localparam int T_DEPTH = FRAMES * TEMPS_PER_FRAME;
    localparam int TA_W    = clog2_min1(T_DEPTH);
    localparam int TC_W    = $clog2(TEMPS_PER_FRAME + 1);
    localparam int FD_W    = clog2_min1(FRAMES);
    localparam int PC_W    = $clog2(PARAM_DEPTH + 1);
    localparam int PA_W    = clog2_min1(PARAM_DEPTH);
    localparam int DA_W    = clog2_min1(DATA_WORDS);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_RD1  = 3'd1;
    localparam logic [2:0] B_RD2  = 3'd2;
    localparam logic [2:0] B_EXEC = 3'd3;
    localparam logic [2:0] B_MUL  = 3'd4;
    localparam logic [2:0] B_DIV  = 3'd5;
    localparam logic [2:0] B_FIN  = 3'd6;

    function automatic logic [TA_W-1:0] tmp_addr(input logic [FD_W-1:0] f,
                                                 input logic [7:0] t);
        return TA_W'(32'(f) * TEMPS_PER_FRAME + 32'(t));
    endfunction

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    rvm_item_t        cur_reg;
    logic [15:0]      pc_reg;
    logic [63:0]      acc_reg;
    logic [3:0]       held_reg;
    logic [FD_W-1:0]  fd_reg;
    logic [PC_W-1:0]  pcnt_reg;
    logic [REGS-1:0]  rvalid_reg;
    logic [T_DEPTH-1:0] tvalid_reg;
    logic [TC_W-1:0]  tcount_reg [FRAMES];
    logic             rd_acc_reg;
    logic             rd_tmp_reg;
    logic             rd_vb_reg;
    logic [63:0]      a_val_reg;
    logic [63:0]      b_val_reg;
    logic [63:0]      mul_acc_reg;
    logic [63:0]      mul_a_reg;
    logic [63:0]      mul_b_reg;
    logic [1:0]       mul_step_reg;
    logic             out_valid_reg;
    logic [3:0]       out_status_reg;
    logic [15:0]      out_pc_reg;
    logic [63:0]      out_acc_reg;

    // operand read path
    logic [7:0]       rd_sel;
    logic             rd_tmp;
    logic [7:0]       rd_t;
    logic [TA_W-1:0]  rd_taddr;
    logic             rd_vbit;
    logic [63:0]      reg_rdata;
    logic [63:0]      tmp_rdata;
    logic [63:0]      dm_rdata;
    logic [63:0]      ps_rdata;
    logic [15:0]      ret_rdata;
    logic [63:0]      opv;
    logic [63:0]      b_cur;
    logic [TC_W-1:0]  cur_count;

    // execute results
    logic [3:0]       st;
    logic [15:0]      pc_n;
    logic [15:0]      npc;
    logic [63:0]      acc_n;
    logic [3:0]       held_n;
    logic [FD_W-1:0]  fd_n;
    logic [PC_W-1:0]  pcnt_n;
    logic             wr_en;
    logic [63:0]      r;
    logic             dm_we;
    logic [63:0]      dm_wdata;
    logic             ps_we;
    logic [63:0]      ps_wdata;
    logic             ret_we;
    logic             cll_en;
    logic             start_en;
    logic             long_go;
    logic             a_miss;
    logic             b_miss;
    logic             wr_ovf;
    logic             dm_oor;
    logic             in_fin;
    logic [63:0]      long_res;
    logic             commit_en;
    logic             wr_reg_we;
    logic             wr_tmp_we;
    logic [TA_W-1:0]  wr_taddr;
    logic [DA_W-1:0]  dm_addr;
    logic [79:0]      mul_pp;
    logic             div_start;
    logic             div_done;
    logic [63:0]      div_q;

    assign rd_sel   = (state_reg == B_RD2) ? cur_reg.op2 : cur_reg.op1;
    assign rd_tmp   = (state_reg == B_RD2) ? cur_reg.op2_tmp : cur_reg.op1_tmp;
    assign rd_t     = (state_reg == B_RD2) ? cur_reg.t2 : cur_reg.t1;
    assign rd_taddr = tmp_addr(fd_reg, rd_t);
    assign rd_vbit  = rd_tmp ? ((32'(rd_t) < TEMPS_PER_FRAME) && tvalid_reg[rd_taddr])
                             : rvalid_reg[rd_sel[3:0]];

    // unwritten entries read zero
    assign opv = rd_acc_reg ? acc_reg :
                 !rd_vb_reg ? 64'd0 :
                 rd_tmp_reg ? tmp_rdata : reg_rdata;

    assign b_cur     = (state_reg == B_EXEC) ? opv : b_val_reg;
    assign cur_count = tcount_reg[fd_reg];
    assign in_fin    = state_reg == B_FIN;
    assign long_res  = (cur_reg.cmd == CMD_MUL) ? mul_acc_reg : div_q;
    assign dm_addr   = DA_W'({{DA_W{1'b0}}, cur_reg.addr});
    assign wr_taddr  = tmp_addr(fd_reg, cur_reg.t1);

    always_comb begin
        a_miss = cur_reg.op1_tmp && (9'(cur_reg.t1) >= 9'(cur_count));
        b_miss = cur_reg.op2_tmp && (9'(cur_reg.t2) >= 9'(cur_count));
        wr_ovf = cur_reg.op1_tmp && (32'(cur_reg.t1) >= TEMPS_PER_FRAME);
        dm_oor = (9'(cur_reg.addr) >= data_words_used) || (32'(cur_reg.addr) >= DATA_WORDS);
        npc      = pc_reg + 16'd1;
        st       = ST_RUN;
        pc_n     = pc_reg;
        acc_n    = acc_reg;
        held_n   = held_reg;
        fd_n     = fd_reg;
        pcnt_n   = pcnt_reg;
        wr_en    = 1'b0;
        r        = '0;
        dm_we    = 1'b0;
        dm_wdata = cur_reg.imm;
        ps_we    = 1'b0;
        ps_wdata = cur_reg.imm;
        ret_we   = 1'b0;
        cll_en   = 1'b0;
        start_en = 1'b0;
        long_go  = 1'b0;
        unique case (cur_reg.kind)
            KIND_START: begin
                start_en = 1'b1;
                pc_n     = cur_reg.imm[15:0];
                held_n   = ST_RUN;
                fd_n     = '0;
                pcnt_n   = '0;
                acc_n    = '0;
            end
            KIND_ARG: begin
                if (32'(pcnt_reg) < PARAM_DEPTH) begin
                    ps_we  = 1'b1;
                    pcnt_n = pcnt_reg + 1'b1;
                end else begin
                    st = ST_OVF;
                end
            end
            KIND_PRELOAD: begin
                if (32'(cur_reg.addr) < DATA_WORDS) begin
                    dm_we = 1'b1;
                end else begin
                    st = ST_DATA;
                end
            end
            default: begin
                priority if (held_reg != ST_RUN) begin
                    st = held_reg;
                end else if (pc_reg >= program_length) begin
                    st     = ST_OUTP;
                    held_n = ST_OUTP;
                end else begin
                    unique case (cur_reg.cmd)
                        CMD_NOP: begin
                        end
                        CMD_STO: begin
                            priority if (b_miss) st = ST_TEMP;
                            else if (wr_ovf) st = ST_OVF;
                            else begin
                                r = b_cur; wr_en = 1'b1;
                            end
                        end
                        CMD_STI, CMD_STP: begin
                            if (wr_ovf) begin
                                st = ST_OVF;
                            end else begin
                                r = (cur_reg.cmd == CMD_STI) ? cur_reg.imm
                                                             : 64'(cur_reg.addr);
                                wr_en = 1'b1;
                            end
                        end
                        CMD_STM: begin
                            priority if (dm_oor) st = ST_DATA;
                            else if (wr_ovf) st = ST_OVF;
                            else begin
                                r = dm_rdata; wr_en = 1'b1;
                            end
                        end
                        CMD_STD: begin
                            priority if (dm_oor) st = ST_DATA;
                            else if (wr_ovf) st = ST_OVF;
                            else begin
                                r        = a_miss ? 64'd0 : a_val_reg;
                                wr_en    = 1'b1;
                                dm_we    = 1'b1;
                                dm_wdata = r;
                            end
                        end
                        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                            priority if (b_miss || a_miss) begin
                                st = ST_TEMP;
                            end else if (cur_reg.cmd == CMD_DIV && b_cur == 64'd0) begin
                                st = ST_DIV0;
                            end else if (cur_reg.cmd == CMD_ADD) begin
                                r = a_val_reg + b_cur; wr_en = 1'b1;
                            end else if (cur_reg.cmd == CMD_SUB) begin
                                r = a_val_reg - b_cur; wr_en = 1'b1;
                            end else if (in_fin) begin
                                r = long_res; wr_en = 1'b1;
                            end else begin
                                long_go = 1'b1;
                            end
                        end
                        CMD_INC, CMD_DEC: begin
                            if (a_miss) begin
                                st = ST_TEMP;
                            end else begin
                                r = (cur_reg.cmd == CMD_INC) ? a_val_reg + 64'd1
                                                             : a_val_reg - 64'd1;
                                wr_en = 1'b1;
                            end
                        end
                        CMD_EQU, CMD_LTH, CMD_LEQ, CMD_GTH, CMD_GEQ: begin
                            if (a_miss || b_miss) begin
                                st = ST_TEMP;
                            end else begin
                                unique case (cur_reg.cmd)
                                    CMD_EQU: acc_n = 64'(a_val_reg == b_cur);
                                    CMD_LTH: acc_n = 64'($signed(a_val_reg) < $signed(b_cur));
                                    CMD_LEQ: acc_n = 64'($signed(a_val_reg) <= $signed(b_cur));
                                    CMD_GTH: acc_n = 64'($signed(a_val_reg) > $signed(b_cur));
                                    default: acc_n = 64'($signed(a_val_reg) >= $signed(b_cur));
                                endcase
                            end
                        end
                        CMD_PSH: begin
                            priority if (a_miss) st = ST_TEMP;
                            else if (32'(pcnt_reg) >= PARAM_DEPTH) st = ST_OVF;
                            else begin
                                ps_we    = 1'b1;
                                ps_wdata = a_val_reg;
                                pcnt_n   = pcnt_reg + 1'b1;
                                acc_n    = a_val_reg;
                            end
                        end
                        CMD_POP: begin
                            priority if (pcnt_reg == '0) st = ST_EMPTY;
                            else if (wr_ovf) st = ST_OVF;
                            else begin
                                r      = ps_rdata;
                                wr_en  = 1'b1;
                                pcnt_n = pcnt_reg - 1'b1;
                            end
                        end
                        CMD_JMP: npc = cur_reg.target;
                        CMD_JPZ: if (acc_reg == 64'd0) npc = cur_reg.target;
                        CMD_JNZ: if (acc_reg != 64'd0) npc = cur_reg.target;
                        CMD_CLL: begin
                            if (32'(fd_reg) + 1 >= FRAMES) begin
                                st = ST_OVF;
                            end else begin
                                ret_we = 1'b1;
                                fd_n   = fd_reg + 1'b1;
                                cll_en = 1'b1;
                                npc    = cur_reg.target;
                            end
                        end
                        CMD_RET: begin
                            if (fd_reg == '0) begin
                                st = ST_OK;
                            end else begin
                                fd_n = fd_reg - 1'b1;
                                npc  = ret_rdata;
                            end
                        end
                        CMD_NEQ, CMD_ALT, CMD_CLX: st = ST_NIMP;
                        default: st = ST_INV;
                    endcase
                    if (wr_en) begin
                        acc_n = r;
                    end
                    // a faulting instruction leaves all state alone but for the held status
                    if (st != ST_RUN) begin
                        held_n  = st;
                        wr_en   = 1'b0;
                        acc_n   = acc_reg;
                        dm_we   = 1'b0;
                        ps_we   = 1'b0;
                        pcnt_n  = pcnt_reg;
                        fd_n    = fd_reg;
                        ret_we  = 1'b0;
                        cll_en  = 1'b0;
                        long_go = 1'b0;
                    end else begin
                        pc_n = npc;
                    end
                end
            end
        endcase
    end

    assign commit_en = (state_reg == B_EXEC && !long_go) || state_reg == B_FIN;
    assign wr_reg_we = commit_en && wr_en && !cur_reg.op1_tmp && cur_reg.op1 != 8'd0;
    assign wr_tmp_we = commit_en && wr_en && cur_reg.op1_tmp;
    assign div_start = state_reg == B_EXEC && long_go && cur_reg.cmd == CMD_DIV;
    assign mul_pp    = mul_a_reg * mul_b_reg[15:0];
    assign q_ready   = state_reg == B_IDLE && (!out_valid_reg || m_axis_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (q_valid && q_ready) state_next = B_RD1;
            B_RD1:  state_next = B_RD2;
            B_RD2:  state_next = B_EXEC;
            B_EXEC: begin
                if (long_go) begin
                    state_next = (cur_reg.cmd == CMD_MUL) ? B_MUL : B_DIV;
                end else begin
                    state_next = B_IDLE;
                end
            end
            B_MUL:  if (mul_step_reg == 2'd3) state_next = B_FIN;
            B_DIV:  if (div_done) state_next = B_FIN;
            B_FIN:  state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            pc_reg        <= '0;
            acc_reg       <= '0;
            held_reg      <= ST_RUN;
            fd_reg        <= '0;
            pcnt_reg      <= '0;
            rvalid_reg    <= '0;
            tvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int f = 0; f < FRAMES; f++) begin
                tcount_reg[f] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (commit_en) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (commit_en) begin
                pc_reg   <= pc_n;
                acc_reg  <= acc_n;
                held_reg <= held_n;
                fd_reg   <= fd_n;
                pcnt_reg <= pcnt_n;
                if (start_en) begin
                    rvalid_reg <= '0;
                    tvalid_reg <= '0;
                    for (int f = 0; f < FRAMES; f++) begin
                        tcount_reg[f] <= '0;
                    end
                end else begin
                    if (wr_reg_we) begin
                        rvalid_reg[cur_reg.op1[3:0]] <= 1'b1;
                    end
                    if (wr_tmp_we) begin
                        tvalid_reg[wr_taddr] <= 1'b1;
                        if (9'(cur_reg.t1) >= 9'(cur_count)) begin
                            tcount_reg[fd_reg] <= TC_W'(9'(cur_reg.t1) + 9'd1);
                        end
                    end
                    // a call opens a fresh, empty frame
                    if (cll_en) begin
                        tcount_reg[fd_n] <= '0;
                        for (int f = 0; f < FRAMES; f++) begin
                            if (FD_W'(f) == fd_n) begin
                                tvalid_reg[f*TEMPS_PER_FRAME +: TEMPS_PER_FRAME] <= '0;
                            end
                        end
                    end
                end
            end
        end
        if (q_valid && q_ready) begin
            cur_reg <= q_item;
        end
        rd_acc_reg <= rd_sel == 8'd0;
        rd_tmp_reg <= rd_tmp;
        rd_vb_reg  <= rd_vbit;
        if (state_reg == B_RD2) begin
            a_val_reg <= opv;
        end
        if (state_reg == B_EXEC) begin
            b_val_reg    <= opv;
            mul_acc_reg  <= '0;
            mul_a_reg    <= a_val_reg;
            mul_b_reg    <= opv;
            mul_step_reg <= '0;
        end else if (state_reg == B_MUL) begin
            mul_acc_reg  <= mul_acc_reg + mul_pp[63:0];
            mul_a_reg    <= {mul_a_reg[47:0], 16'd0};
            mul_b_reg    <= {16'd0, mul_b_reg[63:16]};
            mul_step_reg <= mul_step_reg + 1'b1;
        end
        if (commit_en) begin
            out_status_reg <= st;
            out_pc_reg     <= pc_n;
            out_acc_reg    <= acc_n;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_acc_reg, out_pc_reg, out_status_reg};

    rvm_ram #(.WIDTH(64), .DEPTH(REGS)) u_reg_ram (
        .aclk  (aclk),
        .we    (wr_reg_we),
        .waddr (cur_reg.op1[3:0]),
        .wdata (r),
        .raddr (rd_sel[3:0]),
        .rdata (reg_rdata)
    );

    rvm_ram #(.WIDTH(64), .DEPTH(T_DEPTH)) u_tmp_ram (
        .aclk  (aclk),
        .we    (wr_tmp_we),
        .waddr (wr_taddr),
        .wdata (r),
        .raddr (rd_taddr),
        .rdata (tmp_rdata)
    );

    rvm_ram #(.WIDTH(64), .DEPTH(DATA_WORDS)) u_data_ram (
        .aclk  (aclk),
        .we    (commit_en && dm_we),
        .waddr (dm_addr),
        .wdata (dm_wdata),
        .raddr (dm_addr),
        .rdata (dm_rdata)
    );

    rvm_ram #(.WIDTH(64), .DEPTH(PARAM_DEPTH)) u_param_ram (
        .aclk  (aclk),
        .we    (commit_en && ps_we),
        .waddr (PA_W'(pcnt_reg)),
        .wdata (ps_wdata),
        .raddr (PA_W'(pcnt_reg - 1'b1)),
        .rdata (ps_rdata)
    );

    rvm_ram #(.WIDTH(16), .DEPTH(FRAMES)) u_ret_ram (
        .aclk  (aclk),
        .we    (commit_en && ret_we),
        .waddr (fd_reg),
        .wdata (pc_reg + 16'd1),
        .raddr (fd_reg - 1'b1),
        .rdata (ret_rdata)
    );

    rvm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (a_val_reg),
        .divisor  (b_cur),
        .done     (div_done),
        .quotient (div_q)
    );
endmodule
`default_nettype wire
